[rtl/core/rie_pkg.sv]
package rie_pkg;

  // I-type operation codes; code 15 is unused and acts as a no-op
  typedef enum logic [3:0] {
    ACT_ADDI  = 4'd0,
    ACT_SLTI  = 4'd1,
    ACT_SLTIU = 4'd2,
    ACT_XORI  = 4'd3,
    ACT_ORI   = 4'd4,
    ACT_ANDI  = 4'd5,
    ACT_SLLI  = 4'd6,
    ACT_SRLI  = 4'd7,
    ACT_SRAI  = 4'd8,
    ACT_LB    = 4'd9,
    ACT_LH    = 4'd10,
    ACT_LW    = 4'd11,
    ACT_LBU   = 4'd12,
    ACT_LHU   = 4'd13,
    ACT_JALR  = 4'd14
  } action_t;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] rs1_value;
    logic [11:0] immediate;
    logic [31:0] pc;
    logic [31:0] load_data;
    logic [4:0]  dest_index;
  } request_t;

  typedef struct packed {
    logic [31:0] write_value;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] mem_address;
    logic [31:0] next_pc;
    logic        misaligned;
  } result_t;

  // after decode: adders done, immediate widened
  typedef struct packed {
    logic        valid;
    action_t     action;
    logic [31:0] src;
    logic [31:0] imm;
    logic [31:0] addr;
    logic [31:0] link;
    logic [31:0] load_data;
    logic [4:0]  dest;
  } dec_t;

  // after the operation units: candidate values, final select pending
  typedef struct packed {
    logic        valid;
    action_t     action;
    logic        lt_signed;
    logic        lt_unsigned;
    logic [31:0] logic_val;
    logic [31:0] shift_val;
    logic [31:0] load_val;
    logic [31:0] addr;
    logic [31:0] link;
    logic [31:0] target;
    logic [4:0]  dest;
  } ops_t;

endpackage

[rtl/core/rie_decode.sv]
module rie_decode import rie_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  request_t req,
  output dec_t     dec
);

  logic [31:0] imm_ext;

  assign imm_ext = {{20{req.immediate[11]}}, req.immediate};

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else begin
      dec.valid <= req_valid;
    end
    dec.action    <= action_t'(req.action);
    dec.src       <= req.rs1_value;
    dec.imm       <= imm_ext;
    dec.addr      <= req.rs1_value + imm_ext;
    dec.link      <= req.pc + PC_STEP;
    dec.load_data <= req.load_data;
    dec.dest      <= req.dest_index;
  end

endmodule

[rtl/core/rie_ops.sv]
module rie_ops import rie_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  dec_t dec,
  output ops_t ops
);

  logic [4:0]  shamt;
  logic [31:0] shift_val;
  logic [31:0] logic_val;
  logic [31:0] load_val;

  assign shamt = dec.imm[4:0];

  always_comb begin
    unique case (dec.action)
      ACT_SLLI: shift_val = dec.src << shamt;
      ACT_SRAI: shift_val = 32'($signed(dec.src) >>> shamt);
      default:  shift_val = dec.src >> shamt;
    endcase
  end

  always_comb begin
    unique case (dec.action)
      ACT_XORI: logic_val = dec.src ^ dec.imm;
      ACT_ORI:  logic_val = dec.src | dec.imm;
      default:  logic_val = dec.src & dec.imm;
    endcase
  end

  // loads take the low byte or halfword of the load word; the effective address does not pick the lane
  always_comb begin
    unique case (dec.action)
      ACT_LB:  load_val = {{24{dec.load_data[7]}}, dec.load_data[7:0]};
      ACT_LH:  load_val = {{16{dec.load_data[15]}}, dec.load_data[15:0]};
      ACT_LBU: load_val = {24'd0, dec.load_data[7:0]};
      ACT_LHU: load_val = {16'd0, dec.load_data[15:0]};
      default: load_val = dec.load_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ops.valid <= 1'b0;
    end else begin
      ops.valid <= dec.valid;
    end
    ops.action      <= dec.action;
    ops.lt_signed   <= $signed(dec.src) < $signed(dec.imm);
    ops.lt_unsigned <= dec.src < dec.imm;
    ops.logic_val   <= logic_val;
    ops.shift_val   <= shift_val;
    ops.load_val    <= load_val;
    ops.addr        <= dec.addr;
    ops.link        <= dec.link;
    ops.target      <= {dec.addr[31:1], 1'b0};
    ops.dest        <= dec.dest;
  end

endmodule

[rtl/core/rie_writeback.sv]
module rie_writeback import rie_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  ops_t    ops,
  output logic    done,
  output result_t result
);

  result_t res_next;

  always_comb begin
    res_next.write_value  = 32'd0;
    res_next.write_enable = 1'b1;
    res_next.write_index  = ops.dest;
    res_next.mem_address  = ops.addr;
    res_next.next_pc      = ops.link;
    res_next.misaligned   = 1'b0;
    unique case (ops.action)
      ACT_ADDI:  res_next.write_value = ops.addr;
      ACT_SLTI:  res_next.write_value = {31'd0, ops.lt_signed};
      ACT_SLTIU: res_next.write_value = {31'd0, ops.lt_unsigned};
      ACT_XORI, ACT_ORI, ACT_ANDI:
        res_next.write_value = ops.logic_val;
      ACT_SLLI, ACT_SRLI, ACT_SRAI:
        res_next.write_value = ops.shift_val;
      ACT_LB, ACT_LH, ACT_LW, ACT_LBU, ACT_LHU:
        res_next.write_value = ops.load_val;
      ACT_JALR: begin
        res_next.mem_address  = ops.target;
        res_next.next_pc      = ops.target;
        res_next.misaligned   = ops.target[1];
        res_next.write_enable = ~ops.target[1];
        res_next.write_value  = ops.target[1] ? 32'd0 : ops.link;
      end
      default: begin
        res_next.write_enable = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ops.valid;
    end
    result <= res_next;
  end

endmodule

[rtl/core/rv32i_itype_execute_top.sv]
// RV32I I-type execute unit. Takes one request per clock (start); its result
// passes the decode, operation and output registers, with done high for one
// cycle. The receiver cannot stall it: busy is always low, the unit sustains
// one request per cycle. Stages: decode (immediate sign extension, address
// and pc+4 adders), operation units (compares, logic, shifts, load
// extraction, jump target), and result select into the output register. A
// misaligned JALR target raises misaligned, clears write_enable and zeroes
// write_value; next_pc still carries the target. Action code 15 is a no-op.
module rv32i_itype_execute_top import rie_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  dec_t dec;
  ops_t ops;
  logic req_valid;

  // pipeline never holds, so a request is always taken
  assign busy      = 1'b0;
  assign req_valid = start & ~busy;

  // stage 1: decode and adders
  rie_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (request),
    .dec       (dec)
  );

  // stage 2: per-operation units
  rie_ops u_ops (
    .clk (clk),
    .rst (rst),
    .dec (dec),
    .ops (ops)
  );

  // stage 3: result select and output register
  rie_writeback u_writeback (
    .clk    (clk),
    .rst    (rst),
    .ops    (ops),
    .done   (done),
    .result (result)
  );

endmodule

[tb/itype_exec_checker.sv]
// Watches the request and result channels of the I-type execute unit,
// predicts every result and compares it field by field.
module itype_exec_checker import rie_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  request_t request,
  input  logic     done,
  input  result_t  result,
  output int       mismatches,
  output int       outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] JALR_TARGET_MASK = ~32'd1;

  result_t expected_results[$];

  // Expected outcome of one I-type request.
  function automatic result_t execute_itype(request_t req);
    logic [31:0] imm;
    logic [31:0] src;
    logic [31:0] ld;
    logic [31:0] ea;
    logic [31:0] link;
    logic [4:0]  shamt;
    result_t     r;
    imm   = {{20{req.immediate[11]}}, req.immediate};
    src   = req.rs1_value;
    ld    = req.load_data;
    shamt = imm[4:0];
    ea    = src + imm;
    link  = req.pc + PC_STEP;
    r.write_value  = '0;
    r.write_enable = 1'b1;
    r.write_index  = req.dest_index;
    r.next_pc      = link;
    r.misaligned   = 1'b0;
    case (req.action)
      ACT_ADDI:  r.write_value = ea;
      ACT_SLTI:  r.write_value = {31'd0, $signed(src) < $signed(imm)};
      ACT_SLTIU: r.write_value = {31'd0, src < imm};
      ACT_XORI:  r.write_value = src ^ imm;
      ACT_ORI:   r.write_value = src | imm;
      ACT_ANDI:  r.write_value = src & imm;
      ACT_SLLI:  r.write_value = src << shamt;
      ACT_SRLI:  r.write_value = src >> shamt;
      ACT_SRAI:  r.write_value = $unsigned($signed(src) >>> shamt);
      ACT_LB:    r.write_value = {{24{ld[7]}}, ld[7:0]};
      ACT_LH:    r.write_value = {{16{ld[15]}}, ld[15:0]};
      ACT_LW:    r.write_value = ld;
      ACT_LBU:   r.write_value = {24'd0, ld[7:0]};
      ACT_LHU:   r.write_value = {16'd0, ld[15:0]};
      ACT_JALR: begin
        ea        = ea & JALR_TARGET_MASK;
        r.next_pc = ea;
        if (ea[1]) begin
          r.misaligned   = 1'b1;
          r.write_enable = 1'b0;
        end else begin
          r.write_value = link;
        end
      end
      default: r.write_enable = 1'b0;  // unused code: no-op
    endcase
    r.mem_address = ea;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatches++;
    end
  endtask

  // both counters are two-state and start at zero
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      expected_results.delete();
    end else begin
      // retire first: a result can never belong to a request taken this edge
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("write_value", want.write_value, result.write_value);
          compare_field("write_enable", 32'(want.write_enable), 32'(result.write_enable));
          compare_field("write_index", 32'(want.write_index), 32'(result.write_index));
          compare_field("mem_address", want.mem_address, result.mem_address);
          compare_field("next_pc", want.next_pc, result.next_pc);
          compare_field("misaligned", 32'(want.misaligned), 32'(result.misaligned));
        end
      end
      if (start && !busy) expected_results.push_back(execute_itype(request));
    end
    outstanding = expected_results.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  import rie_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // unused action code, the unit treats it as a no-op
  localparam logic [3:0] ACT_NOP = 4'hF;
  localparam int RANDOM_REQUESTS = 2000;
  // the last stretch of requests goes back to back, no idle gaps
  localparam int STEADY_TAIL     = 200;
  localparam int PIPE_DRAIN      = 10;
  localparam int REQ_BITS        = $bits(request_t);

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;
  int       mismatches;
  int       outstanding;

  rv32i_itype_execute_top DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  itype_exec_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: ~2000 requests with the longest idle gaps still finish well under
  // 0.5 ms, so this leaves a wide margin.
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic request_t make_request(logic [3:0] act, logic [31:0] src,
                                            logic [11:0] imm, logic [31:0] pc,
                                            logic [31:0] ld, logic [4:0] rd);
    request_t r;
    r.action     = act;
    r.rs1_value  = src;
    r.immediate  = imm;
    r.pc         = pc;
    r.load_data  = ld;
    r.dest_index = rd;
    return r;
  endfunction

  // Word with extra weight on the corner values.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 12'h000;
      1:       return 12'h7FF;
      2:       return 12'h800;
      3:       return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    logic [3:0] act;
    // mostly real operations, now and then the unused code
    if ($urandom_range(0, 29) == 0) act = ACT_NOP;
    else act = 4'($urandom_range(ACT_ADDI, ACT_JALR));
    r = make_request(act, pick_word(), pick_imm(), pick_word(), pick_word(),
                     5'($urandom));
    // half the jumps are forced onto a word boundary so the link path is hit
    if (act == ACT_JALR && $urandom_range(0, 1) == 0) begin
      r.rs1_value[1:0] = 2'b00;
      r.immediate[1:0] = 2'b00;
    end
    return r;
  endfunction

  // Present one request from a falling edge and hold it until it is taken.
  // Leaves start high so the next request can follow back to back.
  task automatic send_request(input request_t r);
    request <= r;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a burst of cycles; the payload carries junk meanwhile.
  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 15);
    start   <= 1'b0;
    request <= request_t'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
    repeat (n) @(negedge clk);
  endtask

  request_t directed[$];
  int       wait_cycles;

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;

    // synchronous reset, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: every operation once or more, field extremes,
    // and the special cases (shift amount taken from low immediate bits,
    // destination zero, misaligned jump, odd jump target, unused code).
    directed.push_back(make_request(ACT_ADDI, 32'hFFFF_FFFF, 12'h001, 32'h0, 32'h0, 5'd0));
    directed.push_back(make_request(ACT_ADDI, 32'h7FFF_FFFF, 12'h7FF, 32'hFFFF_FFFC,
                                    32'hFFFF_FFFF, 5'd31));
    directed.push_back(make_request(ACT_ADDI, 32'h0, 12'h800, 32'h0, 32'h0, 5'd1));
    directed.push_back(make_request(ACT_SLTI, 32'hFFFF_FFFF, 12'h000, 32'h4, 32'h0, 5'd2));
    directed.push_back(make_request(ACT_SLTI, 32'h8000_0000, 12'hFFF, 32'h8, 32'h0, 5'd3));
    directed.push_back(make_request(ACT_SLTI, 32'h0000_0005, 12'h005, 32'hC, 32'h0, 5'd4));
    // unsigned compare against the sign-extended immediate
    directed.push_back(make_request(ACT_SLTIU, 32'hFFFF_FFFE, 12'hFFF, 32'h10, 32'h0, 5'd5));
    directed.push_back(make_request(ACT_SLTIU, 32'hFFFF_FFFF, 12'hFFF, 32'h14, 32'h0, 5'd6));
    directed.push_back(make_request(ACT_XORI, 32'hA5A5_A5A5, 12'hFFF, 32'h18, 32'h0, 5'd7));
    directed.push_back(make_request(ACT_ORI, 32'h0000_0000, 12'h800, 32'h1C, 32'h0, 5'd8));
    directed.push_back(make_request(ACT_ANDI, 32'hFFFF_FFFF, 12'h7F0, 32'h20, 32'h0, 5'd9));
    // shift amount from bits 4..0 only; upper bits set to make sure they are ignored
    directed.push_back(make_request(ACT_SLLI, 32'h0000_0001, 12'hFFF, 32'h24, 32'h0, 5'd10));
    directed.push_back(make_request(ACT_SLLI, 32'hFFFF_FFFF, 12'hFE0, 32'h28, 32'h0, 5'd11));
    directed.push_back(make_request(ACT_SRLI, 32'h8000_0000, 12'h01F, 32'h2C, 32'h0, 5'd12));
    directed.push_back(make_request(ACT_SRAI, 32'h8000_0000, 12'h41F, 32'h30, 32'h0, 5'd13));
    directed.push_back(make_request(ACT_SRAI, 32'h8000_0001, 12'h400, 32'h34, 32'h0, 5'd14));
    directed.push_back(make_request(ACT_LB, 32'h1000, 12'h003, 32'h38, 32'h1234_5680, 5'd15));
    directed.push_back(make_request(ACT_LH, 32'h1000, 12'hFFE, 32'h3C, 32'h0000_8001, 5'd16));
    directed.push_back(make_request(ACT_LW, 32'h1000, 12'h004, 32'h40, 32'hDEAD_BEEF, 5'd17));
    directed.push_back(make_request(ACT_LBU, 32'h1000, 12'h000, 32'h44, 32'hFFFF_FFFF, 5'd18));
    directed.push_back(make_request(ACT_LHU, 32'h1000, 12'h002, 32'h48, 32'hFFFF_FFFF, 5'd19));
    // jumps: aligned, odd target (bit 0 dropped), misaligned, wrap through zero
    directed.push_back(make_request(ACT_JALR, 32'h0000_1000, 12'h010, 32'hFFFF_FFFC,
                                    32'h0, 5'd1));
    directed.push_back(make_request(ACT_JALR, 32'h0000_1001, 12'h000, 32'h100, 32'h0, 5'd1));
    directed.push_back(make_request(ACT_JALR, 32'h0000_1000, 12'h002, 32'h104, 32'h0, 5'd1));
    directed.push_back(make_request(ACT_JALR, 32'h0000_0000, 12'hFFC, 32'h108, 32'h0, 5'd0));
    directed.push_back(make_request(ACT_NOP, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFC,
                                    32'hFFFF_FFFF, 5'd31));

    foreach (directed[i]) send_request(directed[i]);

    // Random part: idle bursts scattered in, none in the closing stretch.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i < RANDOM_REQUESTS - STEADY_TAIL && $urandom_range(0, 5) == 0) idle_burst();
      send_request(random_request());
    end
    start <= 1'b0;

    // wait for the pipeline to hand back everything, then a few spare cycles
    // to catch any stray strobe
    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 1000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (PIPE_DRAIN) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rie_pkg.sv
rtl/core/rie_decode.sv
rtl/core/rie_ops.sv
rtl/core/rie_writeback.sv
rtl/core/rv32i_itype_execute_top.sv
tb/itype_exec_checker.sv
tb/testbench.sv
